@@ hw/rtl/fmmp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fmmp_pkg;
  localparam int MOD_W = 31;
  localparam int IDX_W = 63;
  localparam int PROD_W = 2 * MOD_W;
  localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(10);
endpackage
`default_nettype wire

@@ hw/rtl/fibonacci_mod_matrix_power_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// a bit costs a NEXT step plus 8 mulmod ops, or 16 ops when it is set
// throughput: one item at a time; a new index is taken only after the result transfer
// in_stall high while busy or result pending
// reset: modulus returns to 10, control idle, no result pending
module fibonacci_mod_matrix_power_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [fmmp_pkg::MOD_W-1:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [fmmp_pkg::IDX_W-1:0] index,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [fmmp_pkg::MOD_W-1:0] fib_value,
  output logic [fmmp_pkg::MOD_W-1:0] fib_next,
  output logic [fmmp_pkg::MOD_W-1:0] product_mod
);
  import fmmp_pkg::*;

  typedef enum logic [2:0] {IDLE, ISSUE, WAIT, NEXT, PROD, PWAIT, DONE} state_t;

  state_t state;
  logic [MOD_W-1:0] modulus;
  logic [MOD_W-1:0] m;
  logic [IDX_W-1:0] exponent_left;
  logic [MOD_W-1:0] bm [4];
  logic [MOD_W-1:0] rm [4];
  logic [MOD_W-1:0] tm [4];
  logic [MOD_W-1:0] part;
  logic [2:0] op;
  logic mul_phase;
  logic u_start;
  logic u_done;
  logic [MOD_W-1:0] ua;
  logic [MOD_W-1:0] ub;
  logic [MOD_W-1:0] ur;
  logic [MOD_W:0] sum;
  logic [MOD_W-1:0] sum_red;
  logic [1:0] ent;
  logic [MOD_W-1:0] xa [4];
  logic [MOD_W-1:0] xb [4];

  // mul_phase 1: result*base, 0: base*base; op = entry*2 + term
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      xa[k] = mul_phase ? rm[k] : bm[k];
      xb[k] = bm[k];
    end
    ent = op[2:1];
    ua = '0;
    ub = '0;
    case (op[2:0])
      3'd0: begin ua = xa[0]; ub = xb[0]; end
      3'd1: begin ua = xa[1]; ub = xb[2]; end
      3'd2: begin ua = xa[0]; ub = xb[1]; end
      3'd3: begin ua = xa[1]; ub = xb[3]; end
      3'd4: begin ua = xa[2]; ub = xb[0]; end
      3'd5: begin ua = xa[3]; ub = xb[2]; end
      3'd6: begin ua = xa[2]; ub = xb[1]; end
      3'd7: begin ua = xa[3]; ub = xb[3]; end
      default: begin ua = '0; ub = '0; end
    endcase
    if (state == PROD) begin
      ua = rm[1];
      ub = rm[0];
    end
    sum = {1'b0, part} + {1'b0, ur};
    sum_red = (sum >= {1'b0, m}) ? MOD_W'(sum - {1'b0, m}) : sum[MOD_W-1:0];
  end

  assign u_start = (state == ISSUE) || (state == PROD);

  fmmp_mulmod u_mul (
    .clk(clk), .rst(rst), .start(u_start), .a(ua), .b(ub), .m(m),
    .done(u_done), .r(ur)
  );

  assign in_stall = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      modulus <= MODULUS_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) modulus <= cfg_data;
      case (state)
        IDLE: begin
          if (in_valid) begin
            m <= (modulus < MOD_W'(2)) ? MOD_W'(2) : modulus;
            exponent_left <= index;
            bm[0] <= MOD_W'(1); bm[1] <= MOD_W'(1);
            bm[2] <= MOD_W'(1); bm[3] <= '0;
            rm[0] <= MOD_W'(1); rm[1] <= '0;
            rm[2] <= '0; rm[3] <= MOD_W'(1);
            state <= NEXT;
          end
        end
        NEXT: begin
          op <= '0;
          if (exponent_left == '0) begin
            state <= PROD;
          end else begin
            mul_phase <= exponent_left[0];
            state <= ISSUE;
          end
        end
        ISSUE: state <= WAIT;
        WAIT: begin
          if (u_done) begin
            if (!op[0]) begin
              part <= ur;
              op <= op + 1'b1;
              state <= ISSUE;
            end else begin
              tm[ent] <= sum_red;
              if (op[2:0] != 3'd7) begin
                op <= op + 1'b1;
                state <= ISSUE;
              end else begin
                op <= '0;
                if (mul_phase) begin
                  rm[0] <= tm[0]; rm[1] <= tm[1]; rm[2] <= tm[2]; rm[3] <= sum_red;
                  mul_phase <= 1'b0;
                  state <= ISSUE;
                end else begin
                  bm[0] <= tm[0]; bm[1] <= tm[1]; bm[2] <= tm[2]; bm[3] <= sum_red;
                  exponent_left <= exponent_left >> 1;
                  state <= NEXT;
                end
              end
            end
          end
        end
        PROD: state <= PWAIT;
        PWAIT: begin
          if (u_done) begin
            fib_value <= rm[1];
            fib_next <= rm[0];
            product_mod <= ur;
            out_valid <= 1'b1;
            state <= DONE;
          end
        end
        DONE: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/fmmp_mulmod.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fmmp_mulmod (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [fmmp_pkg::MOD_W-1:0] a,
  input  wire logic [fmmp_pkg::MOD_W-1:0] b,
  input  wire logic [fmmp_pkg::MOD_W-1:0] m,
  output logic done,
  output logic [fmmp_pkg::MOD_W-1:0] r
);
  import fmmp_pkg::*;
  localparam int CW = $clog2(MOD_W + 1);

  logic [MOD_W-1:0] areg;
  logic [MOD_W-1:0] mreg;
  logic [CW-1:0] cnt;
  logic busy;
  logic [MOD_W+1:0] dbl;
  logic [MOD_W+1:0] add;
  logic [MOD_W+1:0] acc_d;
  logic [MOD_W-1:0] b_sh;
  logic [MOD_W-1:0] acc;

  // double and add, msb first, with reduction at each step
  always_comb begin
    dbl = {2'b0, acc} << 1;
    if (dbl >= {2'b0, mreg}) dbl = dbl - {2'b0, mreg};
    add = dbl + (b_sh[MOD_W-1] ? {2'b0, areg} : '0);
    acc_d = add;
    if (acc_d >= {2'b0, mreg}) acc_d = acc_d - {2'b0, mreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(MOD_W);
        acc <= '0;
        areg <= (a >= m) ? a - m : a;
        b_sh <= b;
        mreg <= m;
      end else if (busy) begin
        acc <= acc_d[MOD_W-1:0];
        b_sh <= b_sh << 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign r = acc;
endmodule
`default_nettype wire
